// ===== src/gwpc_pkg.sv =====
// Shared types and constants for the grid word pattern counter.
// No dependencies; imported by gwpc_score, the top level and the testbench.
`default_nettype none

package gwpc_pkg;

	localparam int CELL_W      = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int TOTAL_W     = 19;
	localparam int OUT_TDATA_W = 24;
	localparam int HITS_W      = 3;
	localparam int WIN_LEN     = 6;   // columns c-3 .. c+2 kept per row
	localparam int ROWS        = 4;   // current row plus three above it

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd2;

	localparam logic                  MODE_WORD   = 1'b0;
	localparam logic                  MODE_CROSS  = 1'b1;
	localparam logic                  MODE_RESET  = MODE_CROSS;
	localparam logic [CFG_DATA_W-1:0] SIZE_RESET  = 9'd140;

	localparam logic [CELL_W-1:0] CH_X = 8'h58;
	localparam logic [CELL_W-1:0] CH_M = 8'h4D;
	localparam logic [CELL_W-1:0] CH_A = 8'h41;
	localparam logic [CELL_W-1:0] CH_S = 8'h53;

	// window fill sequencer: read steps 0..6 cover columns c-3 .. c+3
	localparam logic [2:0] FILL_SKIP = 3'd3;
	localparam logic [2:0] FILL_LAST = 3'd6;

	typedef enum logic {
		ST_FILL,
		ST_RUN
	} fill_state_t;

	// Cells around the new cell, named by relative row and column offset.
	typedef struct packed {
		logic [CELL_W-1:0] ch;
		logic [CELL_W-1:0] row0_m3;
		logic [CELL_W-1:0] row0_m2;
		logic [CELL_W-1:0] row0_m1;
		logic [CELL_W-1:0] row1_m1;
		logic [CELL_W-1:0] row1_c;
		logic [CELL_W-1:0] row1_p1;
		logic [CELL_W-1:0] row2_m2;
		logic [CELL_W-1:0] row2_c;
		logic [CELL_W-1:0] row2_p2;
		logic [CELL_W-1:0] row3_m3;
		logic [CELL_W-1:0] row3_c;
		logic [CELL_W-1:0] row3_p3;
		logic              mode;
		logic              col_ge2;
		logic              col_ge3;
		logic              row_ge2;
		logic              row_ge3;
		logic              right_fit;
	} gwpc_taps_t;

endpackage

`default_nettype wire

// ===== src/gwpc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gwpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/gwpc_score.sv =====
// Pattern scoring for one cell: word hits on four lines or one cross hit.
// Depends on gwpc_pkg.
`default_nettype none

module gwpc_score
	import gwpc_pkg::*;
(
	input  wire gwpc_taps_t        taps,
	output logic [HITS_W-1:0]      hits
);

	function automatic logic is_word(input logic [CELL_W-1:0] a, input logic [CELL_W-1:0] b,
			input logic [CELL_W-1:0] c, input logic [CELL_W-1:0] d);
		return (a == CH_X && b == CH_M && c == CH_A && d == CH_S) ||
		       (a == CH_S && b == CH_A && c == CH_M && d == CH_X);
	endfunction

	function automatic logic is_ms_pair(input logic [CELL_W-1:0] a,
			input logic [CELL_W-1:0] b);
		return (a == CH_M && b == CH_S) || (a == CH_S && b == CH_M);
	endfunction

	logic hit_row;
	logic hit_col;
	logic hit_diag;
	logic hit_anti;
	logic hit_cross;

	always_comb begin
		hit_row  = taps.col_ge3 &&
			is_word(taps.row0_m3, taps.row0_m2, taps.row0_m1, taps.ch);
		hit_col  = taps.row_ge3 &&
			is_word(taps.row3_c, taps.row2_c, taps.row1_c, taps.ch);
		hit_diag = taps.row_ge3 && taps.col_ge3 &&
			is_word(taps.row3_m3, taps.row2_m2, taps.row1_m1, taps.ch);
		hit_anti = taps.row_ge3 && taps.right_fit &&
			is_word(taps.row3_p3, taps.row2_p2, taps.row1_p1, taps.ch);
		hit_cross = taps.row_ge2 && taps.col_ge2 && (taps.row1_m1 == CH_A) &&
			is_ms_pair(taps.row2_m2, taps.ch) && is_ms_pair(taps.row2_c, taps.row0_m2);

		if (taps.mode == MODE_WORD) begin
			hits = {2'b00, hit_row} + {2'b00, hit_col} + {2'b00, hit_diag} +
				{2'b00, hit_anti};
		end else begin
			hits = {2'b00, hit_cross};
		end
	end

endmodule

`default_nettype wire

// ===== src/grid_word_pattern_counter.sv =====
// Top level of the grid word pattern counter: row RAMs, sliding windows,
// scoring stage and result register. Depends on gwpc_pkg, gwpc_ram, gwpc_score.
`default_nettype none

// Usage
//   s_axis: one grid cell per request (8-bit character), raster order, no
//           line separators. The grid size comes from grid_width/grid_height.
//   m_axis: one request per grid, sent after the last cell: match_total.
//   cfg:    write-only registers (mode, grid_width, grid_height), written
//           while no grid cell is in flight. A write forces a window refill.
// Timing
//   Inside a row the block takes one cell per clock unless the scoring stage
//   is held (see Stall). Each new row (and each config write) first refills
//   the column windows from the row RAMs, skipping the reads left of the grid
//   when the row starts at column 0; tready is low meanwhile. The total passes
//   the scoring stage register and then the result register before m_axis.
// Reset (arst_n low)
//   Position and count go to zero, registers to mode 1 and 140 x 140, and a
//   window refill starts. Row RAM contents are not cleared.
// Stall
//   A held total keeps m_axis_tvalid high; cells of the next grid keep
//   flowing until its last cell reaches the scoring stage, where it waits.
module grid_word_pattern_counter
	import gwpc_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// cell stream
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [CELL_W-1:0]      s_axis_tdata,   // [7:0] cell_char
	// total stream
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [18:0] match_total, rest zero
	// config write port
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int CW = $clog2(MAX_WIDTH);       // column index
	localparam int RW = $clog2(MAX_HEIGHT);      // row index
	localparam int WD = $clog2(MAX_WIDTH + 1);   // effective width
	localparam int HD = $clog2(MAX_HEIGHT + 1);  // effective height
	localparam int XW = WD + 1;                  // column compares
	localparam int YW = HD + 1;                  // row compares

	localparam logic [CW-1:0] COL_BACK3 = CW'(3);
	localparam logic [CW-1:0] COL_AHEAD3 = CW'(3);
	localparam logic [CW-1:0] COL_AHEAD4 = CW'(4);

	// configuration registers
	logic                  mode_q;
	logic [CFG_DATA_W-1:0] width_cfg_q;
	logic [CFG_DATA_W-1:0] height_cfg_q;

	// position and effective sizes
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [WD-1:0] w_eff;
	logic [HD-1:0] h_eff;
	logic [CW-1:0] col_eff;
	logic [RW-1:0] row_eff;
	logic [1:0]    row_slot;
	logic          col_last;
	logic          row_last;

	// fill sequencer
	fill_state_t state_q;
	fill_state_t state_next;
	logic [2:0]  fill_cnt_q;
	logic [2:0]  fill_idx;
	logic        win_shift;
	logic        accept;
	logic        s1_free;

	// row RAMs and windows (window k holds row r-k, columns c-3 .. c+2)
	logic [CW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata [ROWS];
	logic [CELL_W-1:0] dout_rel  [ROWS];
	logic [CELL_W-1:0] win_q     [ROWS][WIN_LEN];

	// scoring stage and result
	logic              s1_valid_q;
	logic              s1_last_q;
	gwpc_taps_t        s1_taps;
	gwpc_taps_t        taps_in;
	logic              s1_go;
	logic [HITS_W-1:0] hits;
	logic [TOTAL_W-1:0] count_q;
	logic [TOTAL_W-1:0] count_sum;
	logic              out_valid_q;
	logic [TOTAL_W-1:0] out_total_q;

	// ---------------------------------------------------------------
	// Effective sizes: zero reads as one, oversize clamps to the maximum.
	// A position left beyond a shrunk grid clamps to the last column/row.
	// ---------------------------------------------------------------
	always_comb begin
		if (width_cfg_q == '0) begin
			w_eff = WD'(1);
		end else if (32'(width_cfg_q) > 32'(MAX_WIDTH)) begin
			w_eff = WD'(MAX_WIDTH);
		end else begin
			w_eff = WD'(width_cfg_q);
		end

		if (height_cfg_q == '0) begin
			h_eff = HD'(1);
		end else if (32'(height_cfg_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HD'(MAX_HEIGHT);
		end else begin
			h_eff = HD'(height_cfg_q);
		end

		if (XW'(col_q) >= XW'(w_eff)) begin
			col_eff = CW'(w_eff - WD'(1));
		end else begin
			col_eff = col_q;
		end

		if (YW'(row_q) >= YW'(h_eff)) begin
			row_eff = RW'(h_eff - HD'(1));
		end else begin
			row_eff = row_q;
		end

		row_slot = row_eff[1:0];
		col_last = (XW'(col_eff) + XW'(1)) >= XW'(w_eff);
		row_last = (YW'(row_eff) + YW'(1)) >= YW'(h_eff);
	end

	// ---------------------------------------------------------------
	// Fill sequencer. At column 0 the reads left of the grid are skipped.
	// ---------------------------------------------------------------
	assign fill_idx = (fill_cnt_q < FILL_SKIP && col_eff == '0) ? FILL_SKIP : fill_cnt_q;
	assign accept   = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_FILL: begin
				if (!cfg_wr_en && fill_idx == FILL_LAST) begin
					state_next = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cfg_wr_en || (accept && col_last)) begin
					state_next = ST_FILL;
				end
			end
			default: begin
				state_next = ST_FILL;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		win_shift     = 1'b0;
		ram_raddr     = col_eff + COL_AHEAD3;
		case (state_q)
			ST_FILL: begin
				win_shift = 1'b1;
				ram_raddr = col_eff + CW'(fill_idx) - COL_BACK3;
			end
			ST_RUN: begin
				s_axis_tready = s1_free;
				win_shift     = accept;
				// keep the RAM output on column c+3 of the position that follows
				ram_raddr     = col_eff + (accept ? COL_AHEAD4 : COL_AHEAD3);
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_FILL;
			fill_cnt_q <= '0;
		end else begin
			state_q <= state_next;
			if (cfg_wr_en || state_q == ST_RUN) begin
				fill_cnt_q <= '0;
			end else begin
				fill_cnt_q <= fill_idx + 3'd1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Configuration and position
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_RESET;
			width_cfg_q  <= SIZE_RESET;
			height_cfg_q <= SIZE_RESET;
			col_q        <= '0;
			row_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MODE:        mode_q       <= cfg_wdata[0];
					REG_GRID_WIDTH:  width_cfg_q  <= cfg_wdata;
					REG_GRID_HEIGHT: height_cfg_q <= cfg_wdata;
					default: begin
						// unused index, write dropped
					end
				endcase
			end
			if (accept) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_eff + RW'(1);
				end else begin
					col_q <= col_eff + CW'(1);
					row_q <= row_eff;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Row RAMs: grid row r lives in RAM r mod 4, addressed by column.
	// ---------------------------------------------------------------
	for (genvar g = 0; g < ROWS; g++) begin : g_row_ram
		gwpc_ram #(
			.WIDTH(CELL_W),
			.DEPTH(MAX_WIDTH)
		) u_ram (
			.clk  (clk),
			.we   (accept && row_slot == 2'(g)),
			.waddr(col_eff),
			.wdata(s_axis_tdata),
			.raddr(ram_raddr),
			.rdata(ram_rdata[g])
		);
	end

	// RAM outputs reordered to rows above the current one
	always_comb begin
		for (int k = 0; k < ROWS; k++) begin
			dout_rel[k] = ram_rdata[2'(row_slot - 2'(k))];
		end
	end

	// Windows slide by one column per shift; the RAM output is column c+3.
	// In the current row the new cell replaces the slot for column c.
	always_ff @(posedge clk) begin
		if (win_shift) begin
			for (int k = 0; k < ROWS; k++) begin
				for (int i = 0; i < WIN_LEN - 1; i++) begin
					win_q[k][i] <= win_q[k][i+1];
				end
				win_q[k][WIN_LEN-1] <= dout_rel[k];
			end
			if (accept) begin
				win_q[0][2] <= s_axis_tdata;
			end
		end
	end

	// ---------------------------------------------------------------
	// Scoring stage
	// ---------------------------------------------------------------
	always_comb begin
		taps_in.ch        = s_axis_tdata;
		taps_in.row0_m3   = win_q[0][0];
		taps_in.row0_m2   = win_q[0][1];
		taps_in.row0_m1   = win_q[0][2];
		taps_in.row1_m1   = win_q[1][2];
		taps_in.row1_c    = win_q[1][3];
		taps_in.row1_p1   = win_q[1][4];
		taps_in.row2_m2   = win_q[2][1];
		taps_in.row2_c    = win_q[2][3];
		taps_in.row2_p2   = win_q[2][5];
		taps_in.row3_m3   = win_q[3][0];
		taps_in.row3_c    = win_q[3][3];
		taps_in.row3_p3   = dout_rel[3];
		taps_in.mode      = mode_q;
		taps_in.col_ge2   = col_eff >= CW'(2);
		taps_in.col_ge3   = col_eff >= CW'(3);
		taps_in.row_ge2   = row_eff >= RW'(2);
		taps_in.row_ge3   = row_eff >= RW'(3);
		taps_in.right_fit = (XW'(col_eff) + XW'(3)) < XW'(w_eff);
	end

	// the last cell of a grid waits here while an earlier total is unsent
	assign s1_go   = s1_valid_q && (!s1_last_q || !out_valid_q || m_axis_tready);
	assign s1_free = !s1_valid_q || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_taps   <= taps_in;
			s1_last_q <= col_last && row_last;
		end
	end

	gwpc_score u_score (
		.taps(s1_taps),
		.hits(hits)
	);

	assign count_sum = count_q + TOTAL_W'(hits);

	// ---------------------------------------------------------------
	// Running count and result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_go) begin
				count_q <= s1_last_q ? '0 : count_sum;
			end
			if (s1_go && s1_last_q) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_last_q) begin
			out_total_q <= count_sum;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - TOTAL_W)'(0), out_total_q};

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking bench for grid_word_pattern_counter: streams character grids
// in, checks each grid total against a behavioral count of words and crosses.
// Depends on gwpc_pkg and the block's RTL; needs no other file.
`default_nettype none

module testbench;
	import gwpc_pkg::*;

	localparam int MAX_W         = 256;
	localparam int MAX_H         = 256;
	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 12;
	// settle margin for the scoring and result registers and a window refill
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_CYCLES  = 24;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int CELL_TARGET   = 1400;
	localparam int GRID_TARGET   = 40;
	localparam int QUIET_AFTER   = 1200;   // no idling on either side past this
	localparam int NUM_DIRECTED  = 34;
	// unmapped register index; a write there must change nothing
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	// ---------------------------------------------------------------
	// DUT hookup; every input has a known value from time zero
	// ---------------------------------------------------------------
	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [CELL_W-1:0]      s_axis_tdata  = '0;   // [7:0] cell_char
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [18:0] match_total, rest zero
	logic                   cfg_wr_en     = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;

	grid_word_pattern_counter #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// ---------------------------------------------------------------
	// Scoreboard counter: own copy of the four-row store, the raster
	// position, the running count and the three registers.
	// ---------------------------------------------------------------
	logic [CELL_W-1:0]     row_mem [0:4*MAX_W-1];
	int unsigned           col_pos    = 0;
	int unsigned           row_pos    = 0;
	logic [TOTAL_W-1:0]    grid_count = '0;
	logic                  mode_reg   = MODE_RESET;
	logic [CFG_DATA_W-1:0] width_reg  = SIZE_RESET;
	logic [CFG_DATA_W-1:0] height_reg = SIZE_RESET;

	logic [TOTAL_W-1:0] pending_totals [$];   // one per grid whose last cell went in
	logic [TOTAL_W-1:0] want_total;
	int unsigned        fail_count  = 0;
	int unsigned        cells_sent  = 0;
	int unsigned        cycle_count = 0;
	int unsigned        stall_left  = 0;
	int unsigned        gap_pct     = 30;
	bit                 quiet       = 1'b0;

	logic [CELL_W-1:0] grid_buf [0:MAX_W*MAX_H-1];

	// size register as the block sees it: zero acts as one, large saturates
	function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	function automatic logic [CELL_W-1:0] mem_cell(int unsigned r, int unsigned c);
		return row_mem[(r % 4) * MAX_W + (c % MAX_W)];
	endfunction

	// XMAS read either way along a line of four
	function automatic bit is_xmas(logic [CELL_W-1:0] a, logic [CELL_W-1:0] b,
			logic [CELL_W-1:0] c, logic [CELL_W-1:0] d);
		return (a == CH_X && b == CH_M && c == CH_A && d == CH_S) ||
			(a == CH_S && b == CH_A && c == CH_M && d == CH_X);
	endfunction

	function automatic bit is_ms(logic [CELL_W-1:0] a, logic [CELL_W-1:0] b);
		return (a == CH_M && b == CH_S) || (a == CH_S && b == CH_M);
	endfunction

	// Store one cell, score every window that ends on it, advance the position.
	// grid_end flags the last cell of a grid and hands back that grid's total.
	task automatic count_cell(input logic [CELL_W-1:0] ch, output bit grid_end,
			output logic [TOTAL_W-1:0] total);
		int unsigned w, h, c, r, hits;
		w = clamp_dim(width_reg, MAX_W);
		h = clamp_dim(height_reg, MAX_H);
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = (row_pos >= h) ? h - 1 : row_pos;
		hits = 0;
		grid_end = 1'b0;
		total = '0;
		row_mem[(r % 4) * MAX_W + c] = ch;
		if (mode_reg == MODE_WORD) begin
			// horizontal, vertical and both diagonals, each in both directions
			if (c >= 3 && is_xmas(mem_cell(r, c - 3), mem_cell(r, c - 2),
					mem_cell(r, c - 1), ch))
				hits++;
			if (r >= 3) begin
				if (is_xmas(mem_cell(r - 3, c), mem_cell(r - 2, c), mem_cell(r - 1, c), ch))
					hits++;
				if (c >= 3 && is_xmas(mem_cell(r - 3, c - 3), mem_cell(r - 2, c - 2),
						mem_cell(r - 1, c - 1), ch))
					hits++;
				if (c + 3 < w && is_xmas(mem_cell(r - 3, c + 3), mem_cell(r - 2, c + 2),
						mem_cell(r - 1, c + 1), ch))
					hits++;
			end
		end else begin
			// cross scored at its lower-right corner
			if (r >= 2 && c >= 2 && mem_cell(r - 1, c - 1) == CH_A &&
					is_ms(mem_cell(r - 2, c - 2), ch) &&
					is_ms(mem_cell(r - 2, c), mem_cell(r, c - 2)))
				hits++;
		end
		grid_count = grid_count + TOTAL_W'(hits);
		if (c + 1 >= w) begin
			col_pos = 0;
			if (r + 1 >= h) begin
				grid_end = 1'b1;
				total = grid_count;
				row_pos = 0;
				grid_count = '0;
			end else begin
				row_pos = r + 1;
			end
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	// ---------------------------------------------------------------
	// Drivers. Everything moves with NBAs right after a rising edge, and
	// the handshake is judged on pre-edge values, so there are no races.
	// ---------------------------------------------------------------

	// Register write: only with the block idle. Drop tvalid, let every
	// pending total come back, give the pipe time to settle, then write.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (pending_totals.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_MODE:        mode_reg = val[0];
			REG_GRID_WIDTH:  width_reg = val;
			REG_GRID_HEIGHT: height_reg = val;
			default: ;
		endcase
	endtask

	// One cell request. tvalid stays high on return so back-to-back cells
	// need no second NBA in the same step; a gap lowers it first.
	// A typed total, when given, replaces the scoreboard's one for that grid.
	task automatic send_cell(input logic [CELL_W-1:0] ch, input bit typed,
			input logic [TOTAL_W-1:0] typed_total);
		bit                 grid_end;
		logic [TOTAL_W-1:0] total;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		do
			@(posedge clk);
		while (!s_axis_tready);
		count_cell(ch, grid_end, total);
		if (grid_end)
			pending_totals.push_back(typed ? typed_total : total);
		cells_sent++;
		if (cells_sent >= QUIET_AFTER)
			quiet = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// Grid builder: mostly X/M/A/S with some arbitrary bytes, then a few
	// planted words or crosses (some deliberately broken) so hits are common.
	// ---------------------------------------------------------------
	function automatic logic [CELL_W-1:0] pick_char();
		int unsigned n;
		n = $urandom_range(0, 19);
		case (n % 4)
			0: pick_char = CH_X;
			1: pick_char = CH_M;
			2: pick_char = CH_A;
			default: pick_char = CH_S;
		endcase
		if (n >= 17)
			pick_char = CELL_W'($urandom_range(0, 255));
	endfunction

	task automatic plant_word(input int w, input int h);
		int                dr, dc, r0, c0, k;
		logic [CELL_W-1:0] letter;
		if (w < 4 && h < 4)
			return;
		dr = (h < 4) ? 0 : int'($urandom_range(0, 2)) - 1;
		dc = (w < 4) ? 0 : int'($urandom_range(0, 2)) - 1;
		if (dr == 0 && dc == 0) begin
			if (w >= 4)
				dc = 1;
			else
				dr = 1;
		end
		r0 = (dr > 0) ? $urandom_range(0, h - 4) :
			(dr < 0) ? $urandom_range(3, h - 1) : $urandom_range(0, h - 1);
		c0 = (dc > 0) ? $urandom_range(0, w - 4) :
			(dc < 0) ? $urandom_range(3, w - 1) : $urandom_range(0, w - 1);
		// negative steps lay the word down reversed, so SAMX comes for free
		for (k = 0; k < 4; k++) begin
			case (k)
				0: letter = CH_X;
				1: letter = CH_M;
				2: letter = CH_A;
				default: letter = CH_S;
			endcase
			grid_buf[(r0 + k * dr) * w + c0 + k * dc] = letter;
		end
		if ($urandom_range(0, 4) == 0) begin
			k = $urandom_range(0, 3);
			grid_buf[(r0 + k * dr) * w + c0 + k * dc] = pick_char();
		end
	endtask

	task automatic plant_cross(input int w, input int h);
		int                rc, cc;
		logic [CELL_W-1:0] a, b;
		if (w < 3 || h < 3)
			return;
		rc = $urandom_range(1, h - 2);
		cc = $urandom_range(1, w - 2);
		a = $urandom_range(0, 1) ? CH_M : CH_S;
		b = $urandom_range(0, 1) ? CH_M : CH_S;
		grid_buf[rc * w + cc] = CH_A;
		grid_buf[(rc - 1) * w + cc - 1] = a;
		grid_buf[(rc + 1) * w + cc + 1] = (a == CH_M) ? CH_S : CH_M;
		grid_buf[(rc - 1) * w + cc + 1] = b;
		grid_buf[(rc + 1) * w + cc - 1] = (b == CH_M) ? CH_S : CH_M;
		// broken cross: same letter on both ends of one diagonal
		if ($urandom_range(0, 4) == 0)
			grid_buf[(rc + 1) * w + cc + 1] = a;
	endtask

	// ---------------------------------------------------------------
	// Directed table: register writes and cells. Totals are typed in only
	// for the tiny grids where the answer is obvious.
	// ---------------------------------------------------------------
	typedef struct packed {
		bit                     is_cfg;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0]  val;
		logic [CELL_W-1:0]      ch;
		bit                     typed;
		logic [TOTAL_W-1:0]     total;
	} step_t;

	function automatic step_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		return '{is_cfg: 1'b1, idx: idx, val: val, ch: '0, typed: 1'b0, total: '0};
	endfunction

	function automatic step_t cell_row(logic [CELL_W-1:0] ch);
		return '{is_cfg: 1'b0, idx: '0, val: '0, ch: ch, typed: 1'b0, total: '0};
	endfunction

	function automatic step_t last_row(logic [CELL_W-1:0] ch, logic [TOTAL_W-1:0] total);
		return '{is_cfg: 1'b0, idx: '0, val: '0, ch: ch, typed: 1'b1, total: total};
	endfunction

	step_t directed_steps [0:NUM_DIRECTED-1] = '{
		// one row of four: XMAS forward, then backward
		cfg_row(REG_MODE, CFG_DATA_W'(MODE_WORD)),
		cfg_row(REG_GRID_WIDTH, 9'd4),
		cfg_row(REG_GRID_HEIGHT, 9'd1),
		cell_row(CH_X), cell_row(CH_M), cell_row(CH_A), last_row(CH_S, 19'd1),
		cell_row(CH_S), cell_row(CH_A), cell_row(CH_M), last_row(CH_X, 19'd1),
		// one column of four: vertical XMAS
		cfg_row(REG_GRID_WIDTH, 9'd1),
		cfg_row(REG_GRID_HEIGHT, 9'd4),
		cell_row(CH_X), cell_row(CH_M), cell_row(CH_A), last_row(CH_S, 19'd1),
		// 3x3 cross, filler cells at both byte extremes
		cfg_row(REG_MODE, CFG_DATA_W'(MODE_CROSS)),
		cfg_row(REG_GRID_WIDTH, 9'd3),
		cfg_row(REG_GRID_HEIGHT, 9'd3),
		cell_row(CH_M), cell_row(8'h00), cell_row(CH_S),
		cell_row(8'hFF), cell_row(CH_A), cell_row(8'h00),
		cell_row(CH_M), cell_row(8'hFF), last_row(CH_S, 19'd1),
		// zero sizes act as a 1x1 grid; unmapped index leaves it that way
		cfg_row(REG_GRID_WIDTH, 9'd0),
		cfg_row(REG_GRID_HEIGHT, 9'd0),
		last_row(8'hFF, 19'd0),
		cfg_row(REG_SPARE, 9'h1FF),
		last_row(8'h00, 19'd0)
	};

	// ---------------------------------------------------------------
	// Total receiver: stalls in random bursts, only while bit 9 of cycle_count
	// is set, so there are long stretches with no stall at all.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (quiet || !cycle_count[9]) begin
			m_axis_tready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 8) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 18);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Result check: every accepted total against the oldest pending one.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_totals.size() == 0) begin
				$display("%0t: total request with no grid pending, expected none, got %0d",
					$time, m_axis_tdata[TOTAL_W-1:0]);
				fail_count++;
			end else begin
				want_total = pending_totals.pop_front();
				if (m_axis_tdata[TOTAL_W-1:0] !== want_total) begin
					$display("%0t: match_total mismatch, expected %0d, got %0d",
						$time, want_total, m_axis_tdata[TOTAL_W-1:0]);
					fail_count++;
				end
				if (m_axis_tdata[OUT_TDATA_W-1:TOTAL_W] !== '0) begin
					$display("%0t: tdata padding mismatch, expected 0, got %0h",
						$time, m_axis_tdata[OUT_TDATA_W-1:TOTAL_W]);
					fail_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence: reset, directed table, random grids, drain.
	// ---------------------------------------------------------------
	initial begin : stimulus
		logic                  mode_v;
		logic [CFG_DATA_W-1:0] width_v, height_v;
		int                    w, h, plants, i;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[n]) begin
			if (directed_steps[n].is_cfg)
				write_reg(directed_steps[n].idx, directed_steps[n].val);
			else
				send_cell(directed_steps[n].ch, directed_steps[n].typed,
					directed_steps[n].total);
		end

		// Random grids, all registers rewritten between grids. Mostly small
		// sizes; two long thin grids hit the saturated width and height.
		for (int g = 0; cells_sent < CELL_TARGET || g < GRID_TARGET; g++) begin
			if (g == 6) begin
				mode_v = MODE_WORD;
				width_v = '1;
				height_v = 9'd1;
			end else if (g == 18) begin
				mode_v = MODE_WORD;
				width_v = 9'd1;
				height_v = '1;
			end else begin
				mode_v = $urandom_range(0, 1) ? MODE_CROSS : MODE_WORD;
				width_v = ($urandom_range(0, 9) == 0) ? 9'd0 : CFG_DATA_W'($urandom_range(1, 9));
				height_v = ($urandom_range(0, 9) == 0) ? 9'd0 : CFG_DATA_W'($urandom_range(1, 9));
			end
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 40;
			endcase

			write_reg(REG_MODE, CFG_DATA_W'(mode_v));
			write_reg(REG_GRID_WIDTH, width_v);
			write_reg(REG_GRID_HEIGHT, height_v);
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_SPARE, CFG_DATA_W'($urandom));

			w = clamp_dim(width_v, MAX_W);
			h = clamp_dim(height_v, MAX_H);
			for (i = 0; i < w * h; i++)
				grid_buf[i] = pick_char();
			plants = $urandom_range(0, 1 + w * h / 16);
			for (i = 0; i < plants; i++) begin
				// mostly the pattern this mode counts, sometimes the other as noise
				if ((mode_v == MODE_WORD) == ($urandom_range(0, 4) != 0))
					plant_word(w, h);
				else
					plant_cross(w, h);
			end
			for (i = 0; i < w * h; i++)
				send_cell(grid_buf[i], 1'b0, '0);
		end

		s_axis_tvalid <= 1'b0;
		while (pending_totals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
